// File: sv/sbf_pkg.sv
// Package for the sprite blitter with X/Y mirroring.
// Holds the register map, flip-mode codes and the structs shared between the modules.
// No dependencies.
package sbf_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_ORIGIN_X      = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y      = 3'd1;
  localparam logic [2:0] REG_SPRITE_WIDTH  = 3'd2;
  localparam logic [2:0] REG_SPRITE_HEIGHT = 3'd3;
  localparam logic [2:0] REG_COLOUR_MODE   = 3'd4;

  // Reset values
  localparam logic [7:0] RST_SIZE        = 8'd8;
  localparam logic [7:0] RST_COLOUR_MODE = 8'd1;

  // Flip-mode codes, high nibble of colour_mode
  localparam logic [3:0] MODE_FLIP_X  = 4'd1;
  localparam logic [3:0] MODE_FLIP_Y  = 4'd2;
  localparam logic [3:0] MODE_FLIP_XY = 4'd3;

  // Configuration register contents
  typedef struct packed {
    logic [7:0] origin_x;
    logic [7:0] origin_y;
    logic [7:0] sprite_width;
    logic [7:0] sprite_height;
    logic [7:0] colour_mode;
  } cfg_t;

  // Input stage contents: pixel plus the counter snapshot it was taken with
  typedef struct packed {
    logic [7:0] pixel;
    logic [7:0] col;
    logic [7:0] row;
    logic       last;
  } stage_t;

  // A zero size counts as one
  function automatic logic [7:0] eff_size(input logic [7:0] size);
    eff_size = (size == 8'd0) ? 8'd1 : size;
  endfunction

endpackage

// File: sv/sprite_blit_flip.sv
// Sprite blitter with X/Y mirroring: pixels in, one frame-buffer write beat out per pixel.
// Top level; depends on sbf_pkg, sbf_cfg, sbf_seq and sbf_pix.
//
// Source pixels arrive one per beat in row-major order; the block tracks column and row
// and emits one write beat per pixel with the mirrored, origin-relative destination,
// the 4-bit shade and a write enable (low when the pixel-colour product is zero; the beat
// is still sent). out_tlast marks the final pixel of the sprite, after which the counters
// restart. Throughput is one pixel per clock while out_tready is high; pixels pass the
// input register and the result register, with ready passing straight back through both.
// Registers should be written only while no pixel is in flight; writes never touch the
// counters.
module sprite_blit_flip
  import sbf_pkg::*;
#(
  parameter int COORD_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  // pixel input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] pixel_value
  // frame-buffer write output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] dest_x, [15:8] dest_y, [19:16] shade, rest zero
  output logic        out_tuser,  // [0] write_enable
  output logic        out_tlast   // last_pixel
);

  cfg_t   cfg;
  stage_t stg;
  logic   stg_valid;
  logic   stg_ready;

  sbf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sbf_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_pixel  (in_tdata),
    .stg_ready (stg_ready),
    .stg_valid (stg_valid),
    .stg       (stg)
  );

  sbf_pix #(
    .COORD_BITS (COORD_BITS)
  ) u_pix (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .stg_valid  (stg_valid),
    .stg        (stg),
    .stg_ready  (stg_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// File: sv/sbf_cfg.sv
// Configuration register file of the sprite blitter.
// Depends on sbf_pkg.
module sbf_cfg
  import sbf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  output cfg_t       cfg
);

  cfg_t cfg_r;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x      <= '0;
      cfg_r.origin_y      <= '0;
      cfg_r.sprite_width  <= RST_SIZE;
      cfg_r.sprite_height <= RST_SIZE;
      cfg_r.colour_mode   <= RST_COLOUR_MODE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_X:      cfg_r.origin_x      <= cfg_wdata;
        REG_ORIGIN_Y:      cfg_r.origin_y      <= cfg_wdata;
        REG_SPRITE_WIDTH:  cfg_r.sprite_width  <= cfg_wdata;
        REG_SPRITE_HEIGHT: cfg_r.sprite_height <= cfg_wdata;
        REG_COLOUR_MODE:   cfg_r.colour_mode   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: sv/sbf_seq.sv
// Column/row sequencer and input register of the sprite blitter.
// Depends on sbf_pkg.
module sbf_seq
  import sbf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_pixel,
  input  logic       stg_ready,
  output logic       stg_valid,
  output stage_t     stg
);

  logic [7:0] col_r, col_nxt;
  logic [7:0] row_r, row_nxt;
  logic       valid_r, valid_nxt;
  stage_t     stg_r;
  logic [7:0] w_eff, h_eff;
  logic       row_end, col_end, last;
  logic       accept;

  // Input register empties when downstream takes it
  assign in_tready = !valid_r || stg_ready;
  assign accept    = in_tvalid && in_tready;

  // End-of-row / end-of-sprite tests on the current counters
  always_comb begin
    w_eff   = eff_size(cfg.sprite_width);
    h_eff   = eff_size(cfg.sprite_height);
    row_end = ({1'b0, col_r} + 9'd1) >= {1'b0, w_eff};
    col_end = ({1'b0, row_r} + 9'd1) >= {1'b0, h_eff};
    last    = row_end && col_end;
  end

  // Counter advance per accepted beat
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
      if (last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = row_r + 8'd1;
      end else begin
        col_nxt = col_r + 8'd1;
      end
    end else if (stg_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Payload capture, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      stg_r.pixel <= in_pixel;
      stg_r.col   <= col_r;
      stg_r.row   <= row_r;
      stg_r.last  <= last;
    end
  end

  assign stg_valid = valid_r;
  assign stg       = stg_r;

endmodule

// File: sv/sbf_pix.sv
// Pixel datapath and result register: mirroring, coordinate add, shade.
// Depends on sbf_pkg.
module sbf_pix
  import sbf_pkg::*;
#(
  parameter int COORD_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        stg_valid,
  input  stage_t      stg,
  output logic        stg_ready,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic        out_tuser,
  output logic        out_tlast
);

  // Wrap to COORD_BITS; above 8 bits the byte-wide output already wraps
  localparam int         MaskBits  = (COORD_BITS < 8) ? COORD_BITS : 8;
  localparam logic [7:0] CoordMask = 8'((1 << MaskBits) - 1);

  logic       valid_r;
  logic [7:0] dx_r, dy_r;
  logic [3:0] shade_r;
  logic       we_r, last_r;

  logic [3:0] mode;
  logic       flip_x, flip_y;
  logic [7:0] off_x, off_y;
  logic [7:0] dx_nxt, dy_nxt;
  logic [7:0] product;
  logic       we_nxt;
  logic [3:0] shade_nxt;

  assign stg_ready = !valid_r || out_tready;

  // Mirror, offset and shade
  always_comb begin
    mode      = cfg.colour_mode[7:4];
    flip_x    = (mode == MODE_FLIP_X) || (mode == MODE_FLIP_XY);
    flip_y    = (mode == MODE_FLIP_Y) || (mode == MODE_FLIP_XY);
    off_x     = flip_x ? (eff_size(cfg.sprite_width)  - 8'd1 - stg.col) : stg.col;
    off_y     = flip_y ? (eff_size(cfg.sprite_height) - 8'd1 - stg.row) : stg.row;
    dx_nxt    = (cfg.origin_x + off_x) & CoordMask;
    dy_nxt    = (cfg.origin_y + off_y) & CoordMask;
    product   = 8'(16'(stg.pixel) * 16'(cfg.colour_mode));
    we_nxt    = (product != 8'd0);
    shade_nxt = product[3:0];
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (stg_ready) begin
      valid_r <= stg_valid;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (stg_ready && stg_valid) begin
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      shade_r <= shade_nxt;
      we_r    <= we_nxt;
      last_r  <= stg.last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {4'd0, shade_r, dy_r, dx_r};
  assign out_tuser  = we_r;
  assign out_tlast  = last_r;

endmodule

// File: test/sbf_write_checker.sv
`timescale 1ns / 1ps
// Checker for the sprite blitter: tracks register writes and pixel beats, predicts each
// frame-buffer write beat and compares it field by field. Depends on sbf_pkg.
module sbf_write_checker
  import sbf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] pixel_value
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // [7:0] dest_x, [15:8] dest_y, [19:16] shade, rest zero
  input  logic        out_tuser,  // [0] write_enable
  input  logic        out_tlast,  // last_pixel
  output int          fail_count,
  output int          pending_writes,
  output int          sprites_done
);

  typedef struct {
    logic       we;
    logic [7:0] dx;
    logic [7:0] dy;
    logic [3:0] shade;
    logic       last;
  } fb_write_t;

  cfg_t       regs;
  logic [7:0] col_cnt;
  logic [7:0] row_cnt;
  fb_write_t  fb_writes_q[$];
  int         n_fail;
  int         n_sprites;

  assign fail_count     = n_fail;
  assign pending_writes = fb_writes_q.size();
  assign sprites_done   = n_sprites;

  // Predict the write for one pixel, then step the column/row counters
  task automatic predict_write(input logic [7:0] pix);
    fb_write_t   e;
    logic [8:0]  w_eff;
    logic [8:0]  h_eff;
    logic [3:0]  mode;
    logic [15:0] prod_full;
    logic [7:0]  prod;
    logic [7:0]  off_x;
    logic [7:0]  off_y;
    logic        row_end;
    logic        col_end;
    w_eff = (regs.sprite_width == 8'd0) ? 9'd1 : {1'b0, regs.sprite_width};
    h_eff = (regs.sprite_height == 8'd0) ? 9'd1 : {1'b0, regs.sprite_height};
    mode = regs.colour_mode[7:4];
    prod_full = {8'd0, pix} * {8'd0, regs.colour_mode};
    prod = prod_full[7:0];
    // counters past a shrunken size count as the last column/row
    row_end = ({1'b0, col_cnt} + 9'd1) >= w_eff;
    col_end = ({1'b0, row_cnt} + 9'd1) >= h_eff;
    off_x = col_cnt;
    off_y = row_cnt;
    if (mode == MODE_FLIP_X || mode == MODE_FLIP_XY) begin
      off_x = 8'(w_eff - 9'd1 - {1'b0, col_cnt});
    end
    if (mode == MODE_FLIP_Y || mode == MODE_FLIP_XY) begin
      off_y = 8'(h_eff - 9'd1 - {1'b0, row_cnt});
    end
    e.we    = (prod != 8'd0);
    e.dx    = regs.origin_x + off_x;
    e.dy    = regs.origin_y + off_y;
    e.shade = prod[3:0];
    e.last  = row_end && col_end;
    fb_writes_q.push_back(e);
    if (e.last) begin
      col_cnt = 8'd0;
      row_cnt = 8'd0;
    end else if (row_end) begin
      col_cnt = 8'd0;
      row_cnt = row_cnt + 8'd1;
    end else begin
      col_cnt = col_cnt + 8'd1;
    end
  endtask

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, exp_v, got_v);
      n_fail++;
    end
  endtask

  // Watch all three ports on every edge
  always @(posedge clk) begin
    fb_write_t e;
    if (!rst_n) begin
      regs.origin_x      = 8'd0;
      regs.origin_y      = 8'd0;
      regs.sprite_width  = RST_SIZE;
      regs.sprite_height = RST_SIZE;
      regs.colour_mode   = RST_COLOUR_MODE;
      col_cnt = 8'd0;
      row_cnt = 8'd0;
      fb_writes_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ORIGIN_X:      regs.origin_x      = cfg_wdata;
          REG_ORIGIN_Y:      regs.origin_y      = cfg_wdata;
          REG_SPRITE_WIDTH:  regs.sprite_width  = cfg_wdata;
          REG_SPRITE_HEIGHT: regs.sprite_height = cfg_wdata;
          REG_COLOUR_MODE:   regs.colour_mode   = cfg_wdata;
          default: ;  // unmapped index, dropped
        endcase
      end
      if (in_tvalid && in_tready) begin
        predict_write(in_tdata);
      end
      if (out_tvalid && out_tready) begin
        if (fb_writes_q.size() == 0) begin
          $display("%0t: unexpected write beat, expected none, got tdata 0x%06h", $time,
                   out_tdata);
          n_fail++;
        end else begin
          e = fb_writes_q.pop_front();
          check_field("write_enable", int'(e.we), int'(out_tuser));
          check_field("dest_x", int'(e.dx), int'(out_tdata[7:0]));
          check_field("dest_y", int'(e.dy), int'(out_tdata[15:8]));
          check_field("shade", int'(e.shade), int'(out_tdata[19:16]));
          check_field("tdata padding", 0, int'(out_tdata[23:20]));
          check_field("last_pixel", int'(e.last), int'(out_tlast));
          if (out_tlast) begin
            n_sprites++;
          end
        end
      end
    end
  end

endmodule

// File: test/sprite_blit_flip_tb.sv
`timescale 1ns / 1ps
// Testbench top for sprite_blit_flip: clock, reset, register programming, pixel stimulus
// and random back-pressure. Depends on sbf_pkg, sprite_blit_flip and sbf_write_checker.
module sprite_blit_flip_tb;
  import sbf_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] pixel_value
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;   // [7:0] dest_x, [15:8] dest_y, [19:16] shade, rest zero
  logic        out_tuser;   // [0] write_enable
  logic        out_tlast;   // last_pixel

  int fail_count;
  int pending_writes;
  int sprites_done;
  int pixels_sent;
  int settings_used;
  bit steady;   // no idling on either side while set

  sprite_blit_flip #(.COORD_BITS(8)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  sbf_write_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .fail_count     (fail_count),
    .pending_writes (pending_writes),
    .sprites_done   (sprites_done)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Frame-buffer side: random stall before each write beat unless steady is set
  initial begin
    int stall;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // One pixel beat after a random gap; valid stays high into the next call
  task automatic send_pixel(input logic [7:0] pix);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    do @(posedge clk); while (!in_tready);
    pixels_sent++;
  endtask

  // Leaves cfg_we high; the caller lowers it
  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Drain the pipe, then program all five registers (and maybe an unmapped index)
  task automatic apply_settings(input logic [7:0] ox, input logic [7:0] oy,
                                input logic [7:0] w, input logic [7:0] h,
                                input logic [7:0] cm, input bit junk);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_writes != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_SPRITE_WIDTH, w);
    write_reg(REG_SPRITE_HEIGHT, h);
    write_reg(REG_COLOUR_MODE, cm);
    if (junk) begin
      write_reg(REG_COLOUR_MODE + 3'($urandom_range(1, 3)), 8'($urandom));
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly small sprites; zero, one and full-range sizes now and then
  function automatic logic [7:0] pick_size();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'hFF;
      default: return 8'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [7:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_colour();
    logic [3:0] mode;
    case ($urandom_range(0, 5))
      0: mode = 4'd0;
      1: mode = MODE_FLIP_X;
      2: mode = MODE_FLIP_Y;
      3: mode = MODE_FLIP_XY;
      default: mode = 4'($urandom);
    endcase
    if ($urandom_range(0, 15) == 0) begin
      return ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
    end
    return {mode, 4'($urandom)};
  endfunction

  initial begin
    int random_sent;
    int area;
    int n;
    logic [7:0] w;
    logic [7:0] h;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_ORIGIN_X;
    cfg_wdata <= 8'd0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'd0;
    steady = 1'b0;
    pixels_sent = 0;
    settings_used = 0;
    random_sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: 8x8, multiplier 1, no mirroring; zero pixel suppresses the write
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h0F);
    // Shrink width below the column counter, mirror X, origins wrap past 255
    apply_settings(8'd250, 8'hFF, 8'd2, 8'd8, {MODE_FLIP_X, 4'h3}, 1'b1);
    send_pixel(8'hAA);
    send_pixel(8'h01);
    // Zero width and height count as one: every pixel ends the sprite
    apply_settings(8'd0, 8'd0, 8'd0, 8'd0, {MODE_FLIP_XY, 4'h7}, 1'b0);
    send_pixel(8'h80);
    send_pixel(8'h7F);
    send_pixel(8'hFF);
    // 3x2 mirrored in Y; 0x10 gives a written beat with zero shade
    apply_settings(8'd5, 8'd9, 8'd3, 8'd2, {MODE_FLIP_Y, 4'hF}, 1'b0);
    send_pixel(8'h10);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h80);
    send_pixel(8'h55);
    send_pixel(8'h11);
    // Zero colour: every write suppressed
    apply_settings(8'd128, 8'd128, 8'd4, 8'd1, 8'h00, 1'b0);
    send_pixel(8'hFF);
    send_pixel(8'h01);
    // Undefined mode nibble draws unmirrored
    apply_settings(8'd1, 8'd2, 8'd2, 8'd2, {4'hF, 4'h1}, 1'b0);
    send_pixel(8'h33);
    send_pixel(8'hC4);
    // Largest sprite, both mirrors, origin at the far corner
    apply_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF, {MODE_FLIP_XY, 4'hF}, 1'b0);
    send_pixel(8'h01);
    send_pixel(8'hFE);
    send_pixel(8'h9C);

    // Random phases: mostly whole small sprites, sometimes cut short mid-sprite
    while (random_sent < 1300) begin
      w = pick_size();
      h = pick_size();
      apply_settings(pick_coord(), pick_coord(), w, h, pick_colour(),
                     $urandom_range(0, 3) == 0);
      steady = ($urandom_range(0, 3) == 0);
      area = ((w == 8'd0) ? 1 : int'(w)) * ((h == 8'd0) ? 1 : int'(h));
      if (area <= 48) begin
        n = area * $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0) n += $urandom_range(1, 5);
      end else begin
        n = $urandom_range(5, 40);
      end
      repeat (n) begin
        send_pixel(rand_pixel());
        random_sent++;
      end
    end

    // Drain and allow a few extra cycles for stray beats
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_writes != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Drove %0d pixel beats over %0d register settings with random gaps and stalls;",
             pixels_sent, settings_used);
    $display("%0d complete sprites drawn, failures: %0d", sprites_done, fail_count);
    if (fail_count == 0 && pending_writes == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/sbf_pkg.sv
sv/sbf_cfg.sv
sv/sbf_seq.sv
sv/sbf_pix.sv
sv/sprite_blit_flip.sv
test/sbf_write_checker.sv
test/sprite_blit_flip_tb.sv
